/* design/blg_pkg.sv */
// Shared types, widths and constants for the battery level gauge.
package blg_pkg;

  localparam int RAW_W      = 8;
  localparam int LVL_W      = 7;
  localparam int SCALE_W    = 16;
  localparam int SCALE_FRAC = 12;
  localparam int STEP_W     = $clog2(LVL_W);
  localparam int SEG_TABLE  = 10;
  localparam int SEG_COUNT  = 10;
  localparam int FRAC_BITS  = 16;

  localparam logic [SCALE_W-1:0] SCALE_ONE  = 16'd4096;
  localparam logic [RAW_W-1:0]   FULL_RAW   = 8'd87;
  localparam logic [LVL_W-1:0]   FULL_LEVEL = 7'd100;
  localparam logic [LVL_W-1:0]   ALERT_HI   = 7'd15;
  localparam logic [LVL_W-1:0]   ALERT_MID  = 7'd10;
  localparam logic [LVL_W-1:0]   ALERT_LO   = 7'd5;

  localparam logic [RAW_W-1:0] SEG_HI [SEG_TABLE+1] = '{
    8'd87, 8'd76, 8'd69, 8'd60, 8'd54, 8'd49, 8'd46, 8'd43, 8'd40, 8'd34, 8'd0
  };

  typedef struct packed {
    logic [RAW_W-1:0] raw_level;
    logic             charging;
  } reading_t;

  typedef struct packed {
    logic [LVL_W-1:0] level;
    logic             alert_15;
    logic             alert_10;
    logic             alert_5;
    logic             low_battery;
  } gauge_t;

endpackage

/* design/blg_cal.sv */
// Bit-serial piecewise-linear calibration of the held level.
module blg_cal import blg_pkg::*; #(
  parameter int SEGMENTS      = SEG_COUNT,
  parameter int FRACTION_BITS = FRAC_BITS
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [LVL_W-1:0] v,
  output logic             done,
  output logic [LVL_W-1:0] lvl
);

  localparam int CW   = FRACTION_BITS + 9;
  localparam int AW   = FRACTION_BITS + 10;
  localparam int SW   = $clog2(SEG_TABLE);
  localparam int NSEG = (SEGMENTS < SEG_TABLE) ? SEGMENTS : SEG_TABLE;
  localparam int QW   = AW - 1 - FRACTION_BITS;

  localparam logic [1:0] C_IDLE = 2'd0;
  localparam logic [1:0] C_RUN  = 2'd1;
  localparam logic [1:0] C_FIN  = 2'd2;

  localparam logic signed [CW-1:0] SLOPE [SEG_TABLE] = '{
    CW'(((64'sd10 << FRACTION_BITS) + 5) / 11),
    CW'(((64'sd10 << FRACTION_BITS) + 3) / 7),
    CW'(((64'sd10 << FRACTION_BITS) + 4) / 9),
    CW'(((64'sd5 << FRACTION_BITS) + 1) / 3),
    CW'((64'sd2 << FRACTION_BITS)),
    CW'(((64'sd10 << FRACTION_BITS) + 1) / 3),
    CW'(((64'sd10 << FRACTION_BITS) + 1) / 3),
    CW'(((64'sd10 << FRACTION_BITS) + 1) / 3),
    CW'(((64'sd5 << FRACTION_BITS) + 1) / 3),
    CW'(((64'sd5 << FRACTION_BITS) + 8) / 17)
  };

  localparam logic signed [CW-1:0] OFFSET [SEG_TABLE] = '{
    CW'(((64'sd230 << FRACTION_BITS) + 5) / 11),
    CW'(-(((64'sd130 << FRACTION_BITS) + 3) / 7)),
    CW'(((64'sd30 << FRACTION_BITS) + 4) / 9),
    CW'(-(((64'sd90 << FRACTION_BITS) + 1) / 3)),
    CW'(-(64'sd48 << FRACTION_BITS)),
    CW'(-(((64'sd340 << FRACTION_BITS) + 1) / 3)),
    CW'(-(((64'sd340 << FRACTION_BITS) + 1) / 3)),
    CW'(-(((64'sd340 << FRACTION_BITS) + 1) / 3)),
    CW'(-(((64'sd140 << FRACTION_BITS) + 1) / 3)),
    CW'(64'sd0)
  };

  logic [1:0]             state;
  logic [STEP_W-1:0]      cnt;
  logic                   hit;
  logic [SW-1:0]          sel;
  logic                   hit_r;
  logic [LVL_W-1:0]       v_r;
  logic [LVL_W-1:0]       mult;
  logic signed [AW-1:0]   mcand;
  logic signed [AW-1:0]   acc;
  logic signed [AW-1:0]   off_r;
  logic signed [AW-1:0]   sum;
  logic signed [AW-1:0]   rnd;
  logic [QW-1:0]          quo;
  logic [LVL_W-1:0]       lvl_next;

  always_comb begin
    hit = 1'b0;
    sel = '0;
    for (int i = 0; i < SEG_TABLE; i++) begin
      if (i < NSEG && {1'b0, v} <= SEG_HI[i] && {1'b0, v} > SEG_HI[i+1]) begin
        hit = 1'b1;
        sel = SW'(i);
      end
    end
  end

  always_comb begin
    sum = acc + off_r;
    rnd = sum + (AW'(1) <<< (FRACTION_BITS - 1));
    quo = rnd[AW-2:FRACTION_BITS];
    if (!hit_r) begin
      lvl_next = (v_r >= FULL_LEVEL) ? FULL_LEVEL : v_r;
    end else if (sum < 0) begin
      lvl_next = '0;
    end else if (quo >= QW'(FULL_LEVEL)) begin
      lvl_next = FULL_LEVEL;
    end else begin
      lvl_next = quo[LVL_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= C_IDLE;
      done  <= 1'b0;
    end else begin
      done <= (state == C_FIN);
      case (state)
        C_IDLE: begin
          if (start) begin
            state <= C_RUN;
          end
        end
        C_RUN: begin
          if (cnt == STEP_W'(LVL_W - 1)) begin
            state <= C_FIN;
          end
        end
        C_FIN: begin
          state <= C_IDLE;
        end
        default: begin
          state <= C_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == C_IDLE && start) begin
      hit_r <= hit;
      v_r   <= v;
      mult  <= v;
      mcand <= AW'(SLOPE[sel]);
      off_r <= AW'(OFFSET[sel]);
      acc   <= '0;
      cnt   <= '0;
    end else if (state == C_RUN) begin
      if (mult[0]) begin
        acc <= acc + mcand;
      end
      mcand <= mcand <<< 1;
      mult  <= mult >> 1;
      cnt   <= cnt + 1'b1;
    end
    if (state == C_FIN) begin
      lvl <= lvl_next;
    end
  end

endmodule

/* design/blg_scale.sv */
// Bit-serial calibration scaling with round-up and clamp.
module blg_scale import blg_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic [LVL_W-1:0]   lvl_in,
  input  logic [SCALE_W-1:0] factor,
  output logic               done,
  output logic [LVL_W-1:0]   lvl
);

  localparam int PW = SCALE_W + LVL_W;
  localparam int QW = PW + 1 - SCALE_FRAC;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_RUN  = 2'd1;
  localparam logic [1:0] S_FIN  = 2'd2;

  logic [1:0]        state;
  logic [STEP_W-1:0] cnt;
  logic [LVL_W-1:0]  mult;
  logic [PW-1:0]     mcand;
  logic [PW-1:0]     prod;
  logic [PW:0]       rnd;
  logic [QW-1:0]     quo;

  assign rnd = {1'b0, prod} + (PW + 1)'((1 << SCALE_FRAC) - 1);
  assign quo = rnd[PW:SCALE_FRAC];

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      done  <= 1'b0;
    end else begin
      done <= (state == S_FIN);
      case (state)
        S_IDLE: begin
          if (start) begin
            state <= S_RUN;
          end
        end
        S_RUN: begin
          if (cnt == STEP_W'(LVL_W - 1)) begin
            state <= S_FIN;
          end
        end
        S_FIN: begin
          state <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_IDLE && start) begin
      mult  <= lvl_in;
      mcand <= PW'(factor);
      prod  <= '0;
      cnt   <= '0;
    end else if (state == S_RUN) begin
      if (mult[0]) begin
        prod <= prod + mcand;
      end
      mcand <= mcand << 1;
      mult  <= mult >> 1;
      cnt   <= cnt + 1'b1;
    end
    if (state == S_FIN) begin
      lvl <= (quo > QW'(FULL_LEVEL)) ? FULL_LEVEL : quo[LVL_W-1:0];
    end
  end

endmodule

/* design/battery_level_gauge_core.sv */
// Battery level gauge: hold logic, serial calibration and scaling, one-shot alerts.
// Each request gives one result. A request runs through two bit-serial multipliers in turn,
// the segment-table calibration and the scale_factor product, each stepping one bit of the
// 7-bit level per cycle and then rounding and clamping, with a registered hand-off between
// the stages, until the result sits in the output register. The next request is accepted on
// the cycle after that register is loaded, so a new request is never taken while the last
// one is in flight, and the output register is loaded only when the output drains.
// scale_factor is written through scale_we and scale_data; the user must write it only while
// no request is in flight, as the block does not enforce this. It resets to 4096 (1.0).
module battery_level_gauge_core import blg_pkg::*; #(
  parameter int SEGMENTS      = SEG_COUNT,
  parameter int FRACTION_BITS = FRAC_BITS
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               scale_we,
  input  logic [SCALE_W-1:0] scale_data,
  input  logic               reading_valid,
  output logic               reading_stall,
  input  reading_t           reading,
  output logic               gauge_valid,
  input  logic               gauge_stall,
  output gauge_t             gauge
);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_CAL   = 2'd1;
  localparam logic [1:0] ST_SCALE = 2'd2;
  localparam logic [1:0] ST_EMIT  = 2'd3;

  logic [1:0]         state;
  logic [SCALE_W-1:0] scale_factor;
  logic [LVL_W-1:0]   previous_level;
  logic               armed_15;
  logic               armed_10;
  logic               armed_5;
  logic               accept;
  logic [LVL_W-1:0]   held;
  logic               cal_done;
  logic [LVL_W-1:0]   cal_lvl;
  logic               scale_start;
  logic               scale_done;
  logic [LVL_W-1:0]   scale_lvl;
  logic               load;
  logic               f15;
  logic               f10;
  logic               f5;

  assign reading_stall = (state != ST_IDLE);
  assign accept        = reading_valid && !reading_stall;
  assign scale_start   = (state == ST_CAL) && cal_done;
  assign load          = (state == ST_EMIT) && (!gauge_valid || !gauge_stall);

  always_comb begin
    if (reading.raw_level > FULL_RAW) begin
      held = FULL_LEVEL;
    end else if (reading.raw_level >= {1'b0, previous_level} && reading.charging) begin
      held = previous_level;
    end else begin
      held = reading.raw_level[LVL_W-1:0];
    end
  end

  assign f15 = (scale_lvl <= ALERT_HI) && !armed_15;
  assign f10 = (scale_lvl <= ALERT_MID) && !armed_10;
  assign f5  = (scale_lvl <= ALERT_LO) && !armed_5;

  blg_cal #(
    .SEGMENTS      (SEGMENTS),
    .FRACTION_BITS (FRACTION_BITS)
  ) u_cal (
    .clk   (clk),
    .rst   (rst),
    .start (accept),
    .v     (held),
    .done  (cal_done),
    .lvl   (cal_lvl)
  );

  blg_scale u_scale (
    .clk    (clk),
    .rst    (rst),
    .start  (scale_start),
    .lvl_in (cal_lvl),
    .factor (scale_factor),
    .done   (scale_done),
    .lvl    (scale_lvl)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= ST_IDLE;
      scale_factor   <= SCALE_ONE;
      previous_level <= FULL_LEVEL;
      armed_15       <= 1'b0;
      armed_10       <= 1'b0;
      armed_5        <= 1'b0;
      gauge_valid    <= 1'b0;
    end else begin
      if (scale_we) begin
        scale_factor <= scale_data;
      end
      if (gauge_valid && !gauge_stall && !load) begin
        gauge_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (accept) begin
            previous_level <= held;
            state          <= ST_CAL;
          end
        end
        ST_CAL: begin
          if (cal_done) begin
            state <= ST_SCALE;
          end
        end
        ST_SCALE: begin
          if (scale_done) begin
            state <= ST_EMIT;
          end
        end
        ST_EMIT: begin
          if (load) begin
            gauge_valid <= 1'b1;
            state       <= ST_IDLE;
            if (scale_lvl > ALERT_HI) begin
              armed_15 <= 1'b0;
              armed_10 <= 1'b0;
              armed_5  <= 1'b0;
            end else begin
              armed_15 <= 1'b1;
              armed_10 <= armed_10 || (scale_lvl <= ALERT_MID);
              armed_5  <= armed_5 || (scale_lvl <= ALERT_LO);
            end
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      gauge.level       <= scale_lvl;
      gauge.alert_15    <= f15;
      gauge.alert_10    <= f10;
      gauge.alert_5     <= f5;
      gauge.low_battery <= f15 || f10 || f5;
    end
  end

endmodule
